[rtl/bsftg_pkg.sv]
// Shared types and constants of the swing-foot trajectory generator.
// Depends on nothing; every other file but bsftg_checker uses it by scoped names.
package bsftg_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_SAMPLES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DS_SAMPLES       = 3'd6;

    // Register reset values
    localparam logic [23:0] RST_STEP_LENGTH      = 24'd19661;
    localparam logic [23:0] RST_STEP_HEIGHT      = 24'd19661;
    localparam logic [23:0] RST_STEP_WIDTH       = 24'd13107;
    localparam logic [24:0] RST_PHASE_INCREMENT  = 25'd239675;
    localparam logic [12:0] RST_SAMPLES_PER_STEP = 13'd81;
    localparam logic [12:0] RST_SWING_SAMPLES    = 13'd70;
    localparam logic [12:0] RST_DS_SAMPLES       = 13'd10;

    // Q1.24 fixed point
    localparam logic [24:0] ONE_Q24  = 25'd16777216;
    localparam logic [23:0] HALF_Q24 = 24'd8388608;

    typedef struct packed {
        logic [23:0] step_length;
        logic [23:0] step_height;
        logic [23:0] step_width;
        logic [24:0] phase_increment;
        logic [12:0] samples_per_step;
        logic [12:0] swing_samples;
        logic [12:0] ds_samples;
    } cfg_t;

    // Datapath operations; a multiply's product is registered with its tag, then written back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_U,
        OP_UU,
        OP_W,
        OP_U3,
        OP_WW,
        OP_P,
        OP_X,
        OP_Z
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        clear_bases;
        logic        emit;
        logic        stepping;
        logic        moving_left;
        logic        half;
        logic        swing;
        logic        step_end;
        logic        last;
        logic [12:0] j;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_sts_t;

endpackage

[rtl/bsftg_if.sv]
// Channel interfaces: command input, sample output, configuration write.
// Depends on bsftg_pkg for field widths.
interface bsftg_cmd_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] step_count;
    logic       left_first;

    modport source (output valid, output func, output step_count, output left_first,
                    input ready);
    modport sink   (input valid, input func, input step_count, input left_first,
                    output ready);
endinterface

interface bsftg_smp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_x;
    logic signed [24:0] left_y;
    logic        [23:0] left_z;
    logic signed [31:0] right_x;
    logic signed [24:0] right_y;
    logic        [23:0] right_z;
    logic               step_end;
    logic               last;

    modport source (output valid, output left_x, output left_y, output left_z,
                    output right_x, output right_y, output right_z,
                    output step_end, output last, input ready);
    modport sink   (input valid, input left_x, input left_y, input left_z,
                    input right_x, input right_y, input right_z,
                    input step_end, input last, output ready);
endinterface

interface bsftg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bsftg_pkg::CFG_IDX_W-1:0]  index;
    logic [bsftg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bsftg_cfg_regs.sv]
// Configuration register file of the trajectory generator.
// Depends on bsftg_pkg and bsftg_cfg_if.
module bsftg_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    bsftg_cfg_if.sink        cfg,
    output bsftg_pkg::cfg_t  regs
);

    bsftg_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.step_length      <= bsftg_pkg::RST_STEP_LENGTH;
            regs_reg.step_height      <= bsftg_pkg::RST_STEP_HEIGHT;
            regs_reg.step_width       <= bsftg_pkg::RST_STEP_WIDTH;
            regs_reg.phase_increment  <= bsftg_pkg::RST_PHASE_INCREMENT;
            regs_reg.samples_per_step <= bsftg_pkg::RST_SAMPLES_PER_STEP;
            regs_reg.swing_samples    <= bsftg_pkg::RST_SWING_SAMPLES;
            regs_reg.ds_samples       <= bsftg_pkg::RST_DS_SAMPLES;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bsftg_pkg::REG_STEP_LENGTH:      regs_reg.step_length      <= cfg.data[23:0];
                bsftg_pkg::REG_STEP_HEIGHT:      regs_reg.step_height      <= cfg.data[23:0];
                bsftg_pkg::REG_STEP_WIDTH:       regs_reg.step_width       <= cfg.data[23:0];
                bsftg_pkg::REG_PHASE_INCREMENT:  regs_reg.phase_increment  <= cfg.data[24:0];
                bsftg_pkg::REG_SAMPLES_PER_STEP: regs_reg.samples_per_step <= cfg.data[12:0];
                bsftg_pkg::REG_SWING_SAMPLES:    regs_reg.swing_samples    <= cfg.data[12:0];
                bsftg_pkg::REG_DS_SAMPLES:       regs_reg.ds_samples       <= cfg.data[12:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[rtl/bsftg_ctrl.sv]
// Plan sequencer: phase counters, step bookkeeping and the multiply schedule.
// Depends on bsftg_pkg and bsftg_cmd_if; drives bsftg_dpath through dp_cmd_t.
module bsftg_ctrl #(
    parameter int MAX_STEPS            = 255,
    parameter int MAX_SAMPLES_PER_STEP = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    bsftg_cmd_if.sink          cmd,
    input  bsftg_pkg::cfg_t    cfg_regs,
    output bsftg_pkg::dp_cmd_t dp_cmd,
    input  bsftg_pkg::dp_sts_t dp_sts
);

    localparam logic [7:0]  STEP_CAP  = 8'((MAX_STEPS < 255) ? MAX_STEPS : 255);
    localparam logic [13:0] SPS_CAP   =
        14'((MAX_SAMPLES_PER_STEP < 8191) ? MAX_SAMPLES_PER_STEP : 8191);
    localparam logic [3:0]  CALC_LAST = 4'd9;

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;
    typedef enum logic [1:0] {PM_IDLE, PM_DS_START, PM_STEP, PM_DS_END} plan_t;

    state_t      state_reg, state_next;
    plan_t       plan_reg, plan_next;
    logic [12:0] si_reg, si_next;
    logic [7:0]  step_idx_reg, step_idx_next;
    logic [7:0]  total_reg, total_next;
    logic        move_left_reg, move_left_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        clr_reg, clr_next;
    logic        ctx_step_reg, ctx_step_next;
    logic        ctx_left_reg, ctx_left_next;
    logic        ctx_half_reg, ctx_half_next;
    logic        ctx_swing_reg, ctx_swing_next;
    logic        ctx_end_reg, ctx_end_next;
    logic        ctx_last_reg, ctx_last_next;
    logic [12:0] ctx_j_reg, ctx_j_next;

    logic [13:0] step_len;
    logic [13:0] si_inc;
    logic [8:0]  idx_inc;
    logic [7:0]  n_clamp;

    // Issue slot of each multiply so that every operand has been written back
    function automatic bsftg_pkg::op_t sched_op(input logic [3:0] c);
        bsftg_pkg::op_t op;
        unique case (c)
            4'd0:    op = bsftg_pkg::OP_U;
            4'd2:    op = bsftg_pkg::OP_UU;
            4'd3:    op = bsftg_pkg::OP_W;
            4'd4:    op = bsftg_pkg::OP_U3;
            4'd5:    op = bsftg_pkg::OP_WW;
            4'd6:    op = bsftg_pkg::OP_P;
            4'd7:    op = bsftg_pkg::OP_X;
            4'd8:    op = bsftg_pkg::OP_Z;
            default: op = bsftg_pkg::OP_NONE;
        endcase
        return op;
    endfunction

    always_comb
    begin
        if (cfg_regs.samples_per_step == 13'd0)
            step_len = 14'd1;
        else if ({1'b0, cfg_regs.samples_per_step} > SPS_CAP)
            step_len = SPS_CAP;
        else
            step_len = {1'b0, cfg_regs.samples_per_step};

        n_clamp = (cmd.step_count < 8'd2) ? 8'd2 : cmd.step_count;
        if (n_clamp > STEP_CAP)
            n_clamp = STEP_CAP;
    end

    assign si_inc    = {1'b0, si_reg} + 14'd1;
    assign idx_inc   = {1'b0, step_idx_reg} + 9'd1;
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        si_next        = si_reg;
        step_idx_next  = step_idx_reg;
        total_next     = total_reg;
        move_left_next = move_left_reg;
        cnt_next       = cnt_reg;
        clr_next       = 1'b0;
        ctx_step_next  = ctx_step_reg;
        ctx_left_next  = ctx_left_reg;
        ctx_half_next  = ctx_half_reg;
        ctx_swing_next = ctx_swing_reg;
        ctx_end_next   = ctx_end_reg;
        ctx_last_next  = ctx_last_reg;
        ctx_j_next     = ctx_j_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && cmd.func)
                begin
                    // restart the plan, bases cleared in the datapath
                    total_next     = n_clamp;
                    move_left_next = cmd.left_first;
                    step_idx_next  = 8'd0;
                    si_next        = 13'd0;
                    plan_next      = (cfg_regs.ds_samples != 13'd0) ? PM_DS_START : PM_STEP;
                    clr_next       = 1'b1;
                end
                else if (cmd.valid && (plan_reg != PM_IDLE))
                begin
                    ctx_step_next  = 1'b0;
                    ctx_left_next  = move_left_reg;
                    ctx_half_next  = 1'b0;
                    ctx_swing_next = 1'b0;
                    ctx_end_next   = 1'b0;
                    ctx_last_next  = 1'b0;
                    ctx_j_next     = si_reg;
                    cnt_next       = 4'd0;
                    state_next     = ST_EMIT;

                    unique case (plan_reg)
                        PM_STEP:
                        begin
                            ctx_step_next  = 1'b1;
                            ctx_half_next  = (step_idx_reg == 8'd0) ||
                                             (idx_inc >= {1'b0, total_reg});
                            ctx_swing_next = (si_reg < cfg_regs.swing_samples);
                            if (si_reg < cfg_regs.swing_samples)
                                state_next = ST_CALC;
                            if (si_inc >= step_len)
                            begin
                                move_left_next = !move_left_reg;
                                step_idx_next  = idx_inc[7:0];
                                si_next        = 13'd0;
                                ctx_end_next   = 1'b1;
                                if (idx_inc >= {1'b0, total_reg})
                                begin
                                    if (cfg_regs.ds_samples == 13'd0)
                                    begin
                                        ctx_last_next = 1'b1;
                                        plan_next     = PM_IDLE;
                                    end
                                    else
                                        plan_next = PM_DS_END;
                                end
                            end
                            else
                                si_next = si_inc[12:0];
                        end
                        PM_DS_START:
                        begin
                            if (si_inc >= {1'b0, cfg_regs.ds_samples})
                            begin
                                si_next   = 13'd0;
                                plan_next = PM_STEP;
                            end
                            else
                                si_next = si_inc[12:0];
                        end
                        PM_DS_END:
                        begin
                            if (si_inc >= {1'b0, cfg_regs.ds_samples})
                            begin
                                si_next       = 13'd0;
                                ctx_last_next = 1'b1;
                                plan_next     = PM_IDLE;
                            end
                            else
                                si_next = si_inc[12:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == CALC_LAST)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!dp_sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plan_reg      <= PM_IDLE;
            si_reg        <= 13'd0;
            step_idx_reg  <= 8'd0;
            total_reg     <= 8'd0;
            move_left_reg <= 1'b1;
            cnt_reg       <= 4'd0;
            clr_reg       <= 1'b0;
            ctx_step_reg  <= 1'b0;
            ctx_left_reg  <= 1'b0;
            ctx_half_reg  <= 1'b0;
            ctx_swing_reg <= 1'b0;
            ctx_end_reg   <= 1'b0;
            ctx_last_reg  <= 1'b0;
            ctx_j_reg     <= 13'd0;
        end
        else
        begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            si_reg        <= si_next;
            step_idx_reg  <= step_idx_next;
            total_reg     <= total_next;
            move_left_reg <= move_left_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            ctx_step_reg  <= ctx_step_next;
            ctx_left_reg  <= ctx_left_next;
            ctx_half_reg  <= ctx_half_next;
            ctx_swing_reg <= ctx_swing_next;
            ctx_end_reg   <= ctx_end_next;
            ctx_last_reg  <= ctx_last_next;
            ctx_j_reg     <= ctx_j_next;
        end
    end

    always_comb
    begin
        dp_cmd.op          = (state_reg == ST_CALC) ? sched_op(cnt_reg) : bsftg_pkg::OP_NONE;
        dp_cmd.clear_bases = clr_reg;
        dp_cmd.emit        = (state_reg == ST_EMIT) && !dp_sts.out_busy;
        dp_cmd.stepping    = ctx_step_reg;
        dp_cmd.moving_left = ctx_left_reg;
        dp_cmd.half        = ctx_half_reg;
        dp_cmd.swing       = ctx_swing_reg;
        dp_cmd.step_end    = ctx_end_reg;
        dp_cmd.last        = ctx_last_reg;
        dp_cmd.j           = ctx_j_reg;
    end

endmodule

[rtl/bsftg_dpath.sv]
// Datapath: shared multiplier with rounding write-back, foot bases, output register.
// Depends on bsftg_pkg and bsftg_smp_if; commanded by bsftg_ctrl.
module bsftg_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  bsftg_pkg::cfg_t    cfg_regs,
    input  bsftg_pkg::dp_cmd_t dp_cmd,
    output bsftg_pkg::dp_sts_t dp_sts,
    bsftg_smp_if.source        smp
);

    logic [27:0]    mul_a;
    logic [24:0]    mul_b;
    logic [52:0]    prod_next, prod_reg;
    bsftg_pkg::op_t tag_reg;
    logic [52:0]    rnd_full;
    logic [28:0]    rnd;
    logic [24:0]    u_sat;

    logic [24:0] u_reg, u2_reg, u3_reg, p_reg;
    logic [22:0] w_reg;
    logic [20:0] w2_reg;
    logic [23:0] x_reg, z_reg;

    logic [26:0] t3, t2, p_raw;
    logic [24:0] p_next;

    logic [23:0] dx_full, dz_full, dx, dz;
    logic [31:0] lx_next, rx_next;
    logic [23:0] lz_next, rz_next;
    logic [22:0] half_w;

    logic [31:0] lbase_reg, rbase_reg;
    logic        out_valid_reg;
    logic [31:0] lx_reg, rx_reg;
    logic [24:0] ly_reg, ry_reg;
    logic [23:0] lz_reg, rz_reg;
    logic        end_reg, last_reg;

    // Operand select for the issued multiply
    always_comb
    begin
        mul_a = 28'd0;
        mul_b = 25'd0;
        case (dp_cmd.op)
            bsftg_pkg::OP_U:
            begin
                mul_a = 28'(dp_cmd.j);
                mul_b = cfg_regs.phase_increment;
            end
            bsftg_pkg::OP_UU:
            begin
                mul_a = 28'(u_reg);
                mul_b = u_reg;
            end
            bsftg_pkg::OP_W:
            begin
                mul_a = 28'(u_reg);
                mul_b = bsftg_pkg::ONE_Q24 - u_reg;
            end
            bsftg_pkg::OP_U3:
            begin
                mul_a = 28'(u2_reg);
                mul_b = u_reg;
            end
            bsftg_pkg::OP_WW:
            begin
                mul_a = 28'(w_reg);
                mul_b = 25'(w_reg);
            end
            bsftg_pkg::OP_X:
            begin
                mul_a = 28'(cfg_regs.step_length);
                mul_b = p_reg;
            end
            bsftg_pkg::OP_Z:
            begin
                mul_a = {cfg_regs.step_height, 4'b0000};
                mul_b = 25'(w2_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign prod_next = 53'(mul_a) * 53'(mul_b);
    assign rnd_full  = prod_reg + 53'(bsftg_pkg::HALF_Q24);
    assign rnd       = rnd_full[52:24];
    assign u_sat     = (prod_reg > 53'(bsftg_pkg::ONE_Q24)) ? bsftg_pkg::ONE_Q24
                                                             : prod_reg[24:0];

    // Blend polynomial 3u^2 - 2u^3, clamped to [0, 1]
    assign t3     = {1'b0, u2_reg, 1'b0} + 27'(u2_reg);
    assign t2     = {1'b0, u3_reg, 1'b0};
    assign p_raw  = (t3 >= t2) ? (t3 - t2) : 27'd0;
    assign p_next = (p_raw > 27'(bsftg_pkg::ONE_Q24)) ? bsftg_pkg::ONE_Q24 : p_raw[24:0];

    // Compose the sample
    always_comb
    begin
        dx_full = dp_cmd.swing ? x_reg : cfg_regs.step_length;
        dz_full = dp_cmd.swing ? z_reg : 24'd0;
        dx      = dp_cmd.half ? (dx_full >> 1) : dx_full;
        dz      = dp_cmd.half ? (dz_full >> 1) : dz_full;
        lx_next = lbase_reg;
        rx_next = rbase_reg;
        lz_next = 24'd0;
        rz_next = 24'd0;
        if (dp_cmd.stepping && dp_cmd.moving_left)
        begin
            lx_next = lbase_reg + 32'(dx);
            lz_next = dz;
        end
        else if (dp_cmd.stepping)
        begin
            rx_next = rbase_reg + 32'(dx);
            rz_next = dz;
        end
    end

    assign half_w = cfg_regs.step_width[23:1];

    // Product pipeline and write-back of intermediates
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (dp_cmd.op == bsftg_pkg::OP_P)
            p_reg <= p_next;
        case (tag_reg)
            bsftg_pkg::OP_U:  u_reg  <= u_sat;
            bsftg_pkg::OP_UU: u2_reg <= rnd[24:0];
            bsftg_pkg::OP_W:  w_reg  <= rnd[22:0];
            bsftg_pkg::OP_U3: u3_reg <= rnd[24:0];
            bsftg_pkg::OP_WW: w2_reg <= rnd[20:0];
            bsftg_pkg::OP_X:  x_reg  <= rnd[23:0];
            bsftg_pkg::OP_Z:  z_reg  <= rnd[23:0];
            default:
            begin
            end
        endcase
        if (dp_cmd.emit)
        begin
            lx_reg   <= lx_next;
            rx_reg   <= rx_next;
            lz_reg   <= lz_next;
            rz_reg   <= rz_next;
            ly_reg   <= 25'd0 - {2'b00, half_w};
            ry_reg   <= {2'b00, half_w};
            end_reg  <= dp_cmd.step_end;
            last_reg <= dp_cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= bsftg_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
            lbase_reg     <= 32'd0;
            rbase_reg     <= 32'd0;
        end
        else
        begin
            tag_reg <= dp_cmd.op;
            if (dp_cmd.emit)
                out_valid_reg <= 1'b1;
            else if (smp.ready)
                out_valid_reg <= 1'b0;
            if (dp_cmd.clear_bases)
            begin
                lbase_reg <= 32'd0;
                rbase_reg <= 32'd0;
            end
            else if (dp_cmd.emit && dp_cmd.step_end)
            begin
                // land the moving foot where the closing sample put it
                if (dp_cmd.moving_left)
                    lbase_reg <= lx_next;
                else
                    rbase_reg <= rx_next;
            end
        end
    end

    assign dp_sts.out_busy = out_valid_reg && !smp.ready;

    assign smp.valid    = out_valid_reg;
    assign smp.left_x   = lx_reg;
    assign smp.left_y   = ly_reg;
    assign smp.left_z   = lz_reg;
    assign smp.right_x  = rx_reg;
    assign smp.right_y  = ry_reg;
    assign smp.right_z  = rz_reg;
    assign smp.step_end = end_reg;
    assign smp.last     = last_reg;

endmodule

[rtl/biped_swing_foot_trajectory_generator.sv]
// A tick during a hold, or in the resting part of a step, goes from acceptance to the
// emit state, which loads the output register; a tick in swing passes the calc state first.
// Emit waits while the sink has not taken the held beat; commands are accepted only in idle.
// In swing, the calc state issues seven dependent products through one 28x25 multiplier.
// Reset (rst_n low, asynchronous): registers to defaults, plan idle, bases at zero,
// no result pending.
module biped_swing_foot_trajectory_generator #(
    parameter int MAX_STEPS            = 255,
    parameter int MAX_SAMPLES_PER_STEP = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    bsftg_cfg_if.sink    cfg,
    bsftg_cmd_if.sink    cmd,
    bsftg_smp_if.source  smp
);

    // Live configuration: user writes only while the block is quiet; not enforced.
    bsftg_pkg::cfg_t    cfg_regs;

    // Controller to datapath: multiply issue, base clear, emit strobe and the
    // per-sample context (which foot moves, half step, swing or rest, flags).
    bsftg_pkg::dp_cmd_t dp_cmd;

    // Datapath back to controller: the output register still holds a beat.
    bsftg_pkg::dp_sts_t dp_sts;

    bsftg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Sequencer: counts hold samples, step samples and steps, decides each
    // sample's flags at acceptance, then schedules the multiplies for swing samples.
    bsftg_ctrl #(
        .MAX_STEPS            (MAX_STEPS),
        .MAX_SAMPLES_PER_STEP (MAX_SAMPLES_PER_STEP)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_regs (cfg_regs),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts)
    );

    // Arithmetic: phase, cubic blend and quartic lift on a shared multiplier,
    // foot base positions, and the output register that decouples the sink.
    bsftg_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts),
        .smp      (smp)
    );

endmodule

[rtl/bsftg_checker.sv]
// Port-level checks of the trajectory generator, bound to the top level.
// Depends only on the top level's ports.
module bsftg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        cmd_func,
    input logic        smp_valid,
    input logic        smp_ready,
    input logic [31:0] left_x,
    input logic [24:0] left_y,
    input logic [23:0] left_z,
    input logic [31:0] right_x,
    input logic [24:0] right_y,
    input logic [23:0] right_z,
    input logic        step_end,
    input logic        last
);

    // Hold a stalled beat
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_ready |=> smp_valid)
        else $error("sample beat dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_ready |=> $stable(left_x) && $stable(right_x) &&
            $stable(left_z) && $stable(right_z) && $stable(step_end) && $stable(last))
        else $error("sample payload changed while stalled");

    // A start beat never produces a sample
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_func |=> !$rose(smp_valid))
        else $error("sample appeared after a start beat");

    // Feet sit symmetric about the center line
    a_lateral: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid |-> (25'(left_y + right_y) == 25'd0))
        else $error("lateral positions not symmetric");

    // At most one foot is lifted
    a_one_lifted: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid |-> (left_z == 24'd0) || (right_z == 24'd0))
        else $error("both feet lifted");

endmodule

bind biped_swing_foot_trajectory_generator bsftg_checker u_bsftg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_func  (cmd.func),
    .smp_valid (smp.valid),
    .smp_ready (smp.ready),
    .left_x    (smp.left_x),
    .left_y    (smp.left_y),
    .left_z    (smp.left_z),
    .right_x   (smp.right_x),
    .right_y   (smp.right_y),
    .right_z   (smp.right_z),
    .step_end  (smp.step_end),
    .last      (smp.last)
);
